// ===== rtl/fall_detector_backtrack_top_assert.svh =====
// Assertion macros used by the fall detector datapath.
`ifndef FALL_DETECTOR_BACKTRACK_TOP_ASSERT_SVH
`define FALL_DETECTOR_BACKTRACK_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define FDB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FDB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/fdb_pkg.sv =====
package fdb_pkg;

  localparam int HIST_DEPTH = 128;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam logic [15:0] ONE_G = 16'd2048;
  localparam logic [7:0]  HIST_FULL = 8'(HIST_DEPTH);
  localparam logic [15:0] CNT_MAX = 16'hFFFF;
  localparam logic [19:0] SD_MAX  = 20'hFFFFF;

  localparam logic [2:0] CFG_FREEFALL  = 3'd0;
  localparam logic [2:0] CFG_IMPACT    = 3'd1;
  localparam logic [2:0] CFG_LOOKBACK  = 3'd2;
  localparam logic [2:0] CFG_MIN_RUN   = 3'd3;
  localparam logic [2:0] CFG_WINDOW    = 3'd4;
  localparam logic [2:0] CFG_GUARD     = 3'd5;
  localparam logic [2:0] CFG_MARGIN    = 3'd6;
  localparam logic [2:0] CFG_ALLOWANCE = 3'd7;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ, S_ROOT, S_ROOT_WAIT, S_MAG, S_UPD, S_DECIDE,
    S_SCAN_RD, S_SCAN_CHK, S_SCAN_END, S_MUL_INIT, S_MUL,
    S_DIV_INIT, S_DIV, S_ROOT_SD, S_SD_WAIT, S_SD, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SQ, OP_ROOT_MAG, OP_MAG, OP_UPD,
    OP_SCAN_RD, OP_SCAN_CHK, OP_SCAN_END, OP_MUL_INIT, OP_MUL,
    OP_DIV_INIT, OP_DIV, OP_ROOT_SD, OP_SD, OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic sq_last;
    logic root_busy;
    logic impact;
    logic scan_last;
    logic mul_last;
    logic div_last;
    logic blk_calc;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/fall_detector_backtrack_top.sv =====
// Fall detector: one accelerometer sample (1/2048 g per LSB) per input beat, one
// result beat per sample. Each beat's magnitude is pushed into a 128-entry
// history ring; an impact outside a watch window walks the ring backwards for a
// free-fall run, then an inactivity window decides fall_alert. On block_end the
// block's magnitude standard deviation (1/32768 g per LSB) is given out.
// Every sample runs on one sequencer: 3 squaring steps on one 16x16 multiplier,
// then 24 steps of the shared two-bit-per-cycle root unit; an impact adds a read
// step and a check step per history entry scanned (one ring read port); a block
// end adds 48 shift-add steps, a 72-step restoring divider and a second root.
// Input is stalled while a sample is in work; the result register lets the next
// sample in while a result waits.
// Configuration writes are taken at any time but are meant for idle periods.
module fall_detector_backtrack_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic               worn,
  input  logic               block_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               fall_alert,
  output logic               motion_valid,
  output logic [19:0]        motion_stddev,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  fdb_pkg::cmd_t cmd;
  fdb_pkg::sts_t sts;

  // sequencer: steps the datapath through each sample
  fdb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: ring, counters, arithmetic units and result register
  fdb_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accel_x       (accel_x),
    .accel_y       (accel_y),
    .accel_z       (accel_z),
    .worn          (worn),
    .block_end     (block_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .fall_alert    (fall_alert),
    .motion_valid  (motion_valid),
    .motion_stddev (motion_stddev)
  );

endmodule

// ===== rtl/fdb_isqrt.sv =====
module fdb_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] radicand,
  output logic        busy,
  output logic [23:0] root
);

  logic [47:0] rad;
  logic [26:0] rem;
  logic [4:0]  cnt;
  logic [26:0] rem_s;
  logic [26:0] trial;

  always_comb begin
    rem_s = {rem[24:0], rad[47:46]};
    trial = {1'b0, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == 5'd23) begin
      busy <= 1'b0;
    end
  end

  // two radicand bits per step, root bit per step
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (busy) begin
      rad <= {rad[45:0], 2'b00};
      cnt <= cnt + 5'd1;
      if (rem_s >= trial) begin
        rem  <= rem_s - trial;
        root <= {root[22:0], 1'b1};
      end else begin
        rem  <= rem_s;
        root <= {root[22:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/fdb_ctrl.sv =====
module fdb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  fdb_pkg::sts_t sts,
  output fdb_pkg::cmd_t cmd
);

  fdb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fdb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = fdb_pkg::OP_NONE;
    in_stall   = (state != fdb_pkg::S_IDLE);
    case (state)
      fdb_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.op     = fdb_pkg::OP_LOAD;
          state_next = fdb_pkg::S_SQ;
        end
      end
      fdb_pkg::S_SQ: begin
        cmd.op = fdb_pkg::OP_SQ;
        if (sts.sq_last) state_next = fdb_pkg::S_ROOT;
      end
      fdb_pkg::S_ROOT: begin
        cmd.op     = fdb_pkg::OP_ROOT_MAG;
        state_next = fdb_pkg::S_ROOT_WAIT;
      end
      fdb_pkg::S_ROOT_WAIT: begin
        if (!sts.root_busy) state_next = fdb_pkg::S_MAG;
      end
      fdb_pkg::S_MAG: begin
        cmd.op     = fdb_pkg::OP_MAG;
        state_next = fdb_pkg::S_UPD;
      end
      fdb_pkg::S_UPD: begin
        cmd.op     = fdb_pkg::OP_UPD;
        state_next = fdb_pkg::S_DECIDE;
      end
      fdb_pkg::S_DECIDE: begin
        if (sts.impact)        state_next = fdb_pkg::S_SCAN_RD;
        else if (sts.blk_calc) state_next = fdb_pkg::S_MUL_INIT;
        else                   state_next = fdb_pkg::S_OUT;
      end
      fdb_pkg::S_SCAN_RD: begin
        if (sts.scan_last) begin
          state_next = fdb_pkg::S_SCAN_END;
        end else begin
          cmd.op     = fdb_pkg::OP_SCAN_RD;
          state_next = fdb_pkg::S_SCAN_CHK;
        end
      end
      fdb_pkg::S_SCAN_CHK: begin
        cmd.op     = fdb_pkg::OP_SCAN_CHK;
        state_next = fdb_pkg::S_SCAN_RD;
      end
      fdb_pkg::S_SCAN_END: begin
        cmd.op     = fdb_pkg::OP_SCAN_END;
        state_next = sts.blk_calc ? fdb_pkg::S_MUL_INIT : fdb_pkg::S_OUT;
      end
      fdb_pkg::S_MUL_INIT: begin
        cmd.op     = fdb_pkg::OP_MUL_INIT;
        state_next = fdb_pkg::S_MUL;
      end
      fdb_pkg::S_MUL: begin
        cmd.op = fdb_pkg::OP_MUL;
        if (sts.mul_last) state_next = fdb_pkg::S_DIV_INIT;
      end
      fdb_pkg::S_DIV_INIT: begin
        cmd.op     = fdb_pkg::OP_DIV_INIT;
        state_next = fdb_pkg::S_DIV;
      end
      fdb_pkg::S_DIV: begin
        cmd.op = fdb_pkg::OP_DIV;
        if (sts.div_last) state_next = fdb_pkg::S_ROOT_SD;
      end
      fdb_pkg::S_ROOT_SD: begin
        cmd.op     = fdb_pkg::OP_ROOT_SD;
        state_next = fdb_pkg::S_SD_WAIT;
      end
      fdb_pkg::S_SD_WAIT: begin
        if (!sts.root_busy) state_next = fdb_pkg::S_SD;
      end
      fdb_pkg::S_SD: begin
        cmd.op     = fdb_pkg::OP_SD;
        state_next = fdb_pkg::S_OUT;
      end
      fdb_pkg::S_OUT: begin
        if (sts.out_free) begin
          cmd.op     = fdb_pkg::OP_OUT;
          state_next = fdb_pkg::S_IDLE;
        end
      end
      default: state_next = fdb_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== rtl/fdb_datapath.sv =====
`include "fall_detector_backtrack_top_assert.svh"

module fdb_datapath (
  input  logic               clk,
  input  logic               rst,
  input  fdb_pkg::cmd_t      cmd,
  output fdb_pkg::sts_t      sts,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic               worn,
  input  logic               block_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               fall_alert,
  output logic               motion_valid,
  output logic [19:0]        motion_stddev
);

  // configuration
  logic [15:0] freefall_level, impact_level, watch_window, guard_samples;
  logic [15:0] motion_margin, motion_allowance;
  logic [7:0]  lookback_depth, min_freefall_run;

  // sample
  logic signed [15:0] ax, ay, az;
  logic        wn, be;
  logic [1:0]  sq_idx;
  logic [31:0] sq;
  logic [15:0] mag;
  logic [31:0] msq;

  // detector state
  logic                       watching;
  logic [fdb_pkg::HIST_AW-1:0] wslot;
  logic [7:0]  fill;
  logic [15:0] since, mcount;
  logic        impact, alert;

  // backtrack scan
  logic [15:0] hist [fdb_pkg::HIST_DEPTH];
  logic [15:0] rdata;
  logic [7:0]  back, depth, run, best;

  // block statistic
  logic [15:0] n, bn;
  logic [31:0] sum, bs;
  logic [47:0] ssq, bss;
  logic [63:0] acc, mcand;
  logic [31:0] mplier, nn;
  logic [5:0]  mk;
  logic [71:0] dvd;
  logic [32:0] drem;
  logic [6:0]  dk;
  logic [19:0] sd;

  // root unit
  logic        root_start, root_busy;
  logic [47:0] root_rad;
  logic [23:0] root;

  // combinational helpers
  logic signed [15:0] sq_op;
  logic signed [31:0] sq_prod;
  logic [15:0] mag_sat, dev, since_n, mcount_n;
  logic [7:0]  fill_n, run_n;
  logic [32:0] drem_s;
  logic [15:0] n_n;
  logic [31:0] sum_n;
  logic [47:0] ssq_n;
  logic        blk_take;

  fdb_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (root_rad),
    .busy     (root_busy),
    .root     (root)
  );

  always_comb begin
    case (sq_idx)
      2'd0:    sq_op = ax;
      2'd1:    sq_op = ay;
      default: sq_op = az;
    endcase
    sq_prod  = 32'(sq_op) * 32'(sq_op);
    mag_sat  = (root[23:16] != 8'd0) ? fdb_pkg::CNT_MAX : root[15:0];
    dev      = (mag >= fdb_pkg::ONE_G) ? mag - fdb_pkg::ONE_G : fdb_pkg::ONE_G - mag;
    fill_n   = (fill == fdb_pkg::HIST_FULL) ? fill : fill + 8'd1;
    since_n  = (since == fdb_pkg::CNT_MAX) ? since : since + 16'd1;
    mcount_n = (since_n > guard_samples && dev > motion_margin && mcount != fdb_pkg::CNT_MAX)
               ? mcount + 16'd1 : mcount;
    run_n    = run + 8'd1;
    drem_s   = {drem[31:0], dvd[71]};
    blk_take = (n != fdb_pkg::CNT_MAX);
    n_n      = blk_take ? n + 16'd1 : n;
    sum_n    = blk_take ? sum + 32'(mag) : sum;
    ssq_n    = blk_take ? ssq + 48'(msq) : ssq;
    root_start = (cmd.op == fdb_pkg::OP_ROOT_MAG) || (cmd.op == fdb_pkg::OP_ROOT_SD);
    root_rad   = (cmd.op == fdb_pkg::OP_ROOT_MAG) ? {16'd0, sq} : dvd[47:0];
  end

  always_comb begin
    sts.sq_last   = (sq_idx == 2'd2);
    sts.root_busy = root_busy;
    sts.impact    = impact;
    sts.scan_last = (back > depth);
    sts.mul_last  = (mk == 6'd47);
    sts.div_last  = (dk == 7'd71);
    sts.blk_calc  = be && (bn != 16'd0);
    sts.out_free  = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      freefall_level   <= 16'd1536;
      impact_level     <= 16'd20480;
      lookback_depth   <= 8'd120;
      min_freefall_run <= 8'd3;
      watch_window     <= 16'd500;
      guard_samples    <= 16'd50;
      motion_margin    <= 16'd512;
      motion_allowance <= 16'd150;
    end else if (cfg_we) begin
      case (cfg_index)
        fdb_pkg::CFG_FREEFALL:  freefall_level   <= cfg_data;
        fdb_pkg::CFG_IMPACT:    impact_level     <= cfg_data;
        fdb_pkg::CFG_LOOKBACK:  lookback_depth   <= cfg_data[7:0];
        fdb_pkg::CFG_MIN_RUN:   min_freefall_run <= cfg_data[7:0];
        fdb_pkg::CFG_WINDOW:    watch_window     <= cfg_data;
        fdb_pkg::CFG_GUARD:     guard_samples    <= cfg_data;
        fdb_pkg::CFG_MARGIN:    motion_margin    <= cfg_data;
        fdb_pkg::CFG_ALLOWANCE: motion_allowance <= cfg_data;
        default: ;
      endcase
    end
  end

  // history ring: written once per sample, read once per scan step
  always_ff @(posedge clk) begin
    if (cmd.op == fdb_pkg::OP_UPD) hist[wslot] <= mag;
    if (cmd.op == fdb_pkg::OP_SCAN_RD) hist_rd: rdata <= hist[wslot - back[fdb_pkg::HIST_AW-1:0]];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      watching  <= 1'b0;
      wslot     <= '0;
      fill      <= '0;
      since     <= '0;
      mcount    <= '0;
      n         <= '0;
      sum       <= '0;
      ssq       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (cmd.op)
        fdb_pkg::OP_UPD: begin
          wslot <= wslot + 1'b1;
          fill  <= fill_n;
          if (watching) begin
            since  <= since_n;
            mcount <= mcount_n;
            if (since_n >= watch_window) watching <= 1'b0;
          end
          n   <= be ? '0 : n_n;
          sum <= be ? '0 : sum_n;
          ssq <= be ? '0 : ssq_n;
        end
        fdb_pkg::OP_SCAN_END: begin
          if (best >= min_freefall_run) begin
            watching <= 1'b1;
            since    <= '0;
            mcount   <= '0;
          end
        end
        default: ;
      endcase
      // result register: load on output, drop once taken
      if (cmd.op == fdb_pkg::OP_OUT) out_valid <= 1'b1;
      else if (!out_stall)           out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      fdb_pkg::OP_LOAD: begin
        ax <= accel_x; ay <= accel_y; az <= accel_z;
        wn <= worn; be <= block_end;
        sq_idx <= '0; sq <= '0;
      end
      fdb_pkg::OP_SQ: begin
        sq     <= sq + 32'(unsigned'(sq_prod));
        sq_idx <= sq_idx + 2'd1;
      end
      fdb_pkg::OP_MAG: begin
        mag <= mag_sat;
        msq <= 32'(mag_sat) * 32'(mag_sat);
      end
      fdb_pkg::OP_UPD: begin
        impact <= !watching && (mag > impact_level);
        alert  <= watching && (since_n >= watch_window) && (mcount_n < motion_allowance) && wn;
        depth  <= (fill_n < lookback_depth) ? fill_n : lookback_depth;
        back   <= 8'd2;
        run    <= '0;
        best   <= '0;
        bn     <= n_n;
        bs     <= sum_n;
        bss    <= ssq_n;
        sd     <= '0;
      end
      fdb_pkg::OP_SCAN_CHK: begin
        back <= back + 8'd1;
        if (rdata < freefall_level) begin
          run <= run_n;
          if (run_n > best) best <= run_n;
        end else begin
          run <= '0;
        end
      end
      fdb_pkg::OP_MUL_INIT: begin
        acc    <= '0;
        mcand  <= {16'd0, bss};
        mplier <= {16'd0, bn};
        mk     <= '0;
        nn     <= 32'(bn) * 32'(bn);
      end
      fdb_pkg::OP_MUL: begin
        // n * sum_sq first, then subtract sum * sum
        if (mplier[0]) acc <= (mk < 6'd16) ? acc + mcand : acc - mcand;
        mk <= mk + 6'd1;
        if (mk == 6'd15) begin
          mcand  <= {32'd0, bs};
          mplier <= bs;
        end else begin
          mcand  <= {mcand[62:0], 1'b0};
          mplier <= {1'b0, mplier[31:1]};
        end
      end
      fdb_pkg::OP_DIV_INIT: begin
        dvd  <= {acc, 8'd0};
        drem <= '0;
        dk   <= '0;
      end
      fdb_pkg::OP_DIV: begin
        dk <= dk + 7'd1;
        if (drem_s >= {1'b0, nn}) begin
          drem <= drem_s - {1'b0, nn};
          dvd  <= {dvd[70:0], 1'b1};
        end else begin
          drem <= drem_s;
          dvd  <= {dvd[70:0], 1'b0};
        end
      end
      fdb_pkg::OP_SD: sd <= (root[23:20] != 4'd0) ? fdb_pkg::SD_MAX : root[19:0];
      fdb_pkg::OP_OUT: begin
        fall_alert    <= alert;
        motion_valid  <= be;
        motion_stddev <= sd;
      end
      default: ;
    endcase
  end

  `FDB_ASSERT_NEXT(a_scan_arms, (cmd.op == fdb_pkg::OP_SCAN_END) && (best >= min_freefall_run), watching, "confirmed free fall did not open a window")
  `FDB_ASSERT_NOW(a_root_idle, root_start, !root_busy, "root unit restarted while busy")
  `FDB_ASSERT_NEXT(a_out_load, cmd.op == fdb_pkg::OP_OUT, out_valid, "result not presented after load")
  `FDB_ASSERT_NOW(a_fill_bound, cmd.op == fdb_pkg::OP_SCAN_RD, depth <= fdb_pkg::HIST_FULL, "scan deeper than ring")

endmodule

// ===== bench/fall_detector_checker.sv =====
`timescale 1ns / 100ps

module fall_detector_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic               worn,
  input  logic               block_end,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               fall_alert,
  input  logic               motion_valid,
  input  logic [19:0]        motion_stddev,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 mismatches,
  output int                 outstanding
);

  typedef struct packed {
    logic        alert;
    logic        sd_valid;
    logic [19:0] sd;
  } verdict_t;

  verdict_t expected_verdicts[$];

  logic [15:0] ff_level, imp_level, win_len, guard_len, margin, allowance;
  logic [7:0]  look_depth, min_run;

  logic        watching;
  logic [15:0] history [fdb_pkg::HIST_DEPTH];
  logic [6:0]  slot;
  logic [7:0]  fill;
  logic [15:0] since_impact, motion_cnt, blk_n;
  longint unsigned blk_sum, blk_sumsq;

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  // Whether the longest free-fall run behind the newest entry, newest one left out, reaches min_run.
  function automatic logic freefall_found();
    int depth, run, best;
    depth = fill;
    run = 0;
    best = 0;
    if (depth > look_depth) depth = look_depth;
    for (int back = 2; back <= depth; back++) begin
      if (history[(int'(slot) + fdb_pkg::HIST_DEPTH - back) % fdb_pkg::HIST_DEPTH]
          < ff_level) begin
        run++;
        if (run > best) best = run;
      end else begin
        run = 0;
      end
    end
    return best >= min_run;
  endfunction

  function automatic verdict_t predict_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                                              logic signed [15:0] az, logic wn, logic last);
    verdict_t v;
    longint signed sx, sy, sz;
    longint unsigned mag, dev, n, d, q, r, scaled, sd;
    sx = ax;
    sy = ay;
    sz = az;
    mag = int_root(longint'(sx * sx + sy * sy + sz * sz));
    if (mag > 65535) mag = 65535;
    dev = (mag >= fdb_pkg::ONE_G) ? mag - fdb_pkg::ONE_G : fdb_pkg::ONE_G - mag;
    v = '0;
    history[slot] = mag[15:0];
    slot = slot + 7'd1;
    if (fill < fdb_pkg::HIST_FULL) fill = fill + 8'd1;
    if (!watching) begin
      if (mag > imp_level && freefall_found()) begin
        watching = 1'b1;
        since_impact = '0;
        motion_cnt = '0;
      end
    end else begin
      if (since_impact != fdb_pkg::CNT_MAX) since_impact++;
      if (since_impact > guard_len && dev > margin && motion_cnt != fdb_pkg::CNT_MAX)
        motion_cnt++;
      if (since_impact >= win_len) begin
        v.alert = (motion_cnt < allowance) && wn;
        watching = 1'b0;
      end
    end
    if (blk_n != fdb_pkg::CNT_MAX) begin
      blk_n++;
      blk_sum += mag;
      blk_sumsq += mag * mag;
    end
    v.sd_valid = last;
    if (last) begin
      n = blk_n;
      if (n != 0) begin
        d = n * blk_sumsq - blk_sum * blk_sum;
        q = d / (n * n);
        r = d % (n * n);
        scaled = q * 256 + (r * 256) / (n * n);
        sd = int_root(scaled);
        v.sd = (sd > fdb_pkg::SD_MAX) ? fdb_pkg::SD_MAX : sd[19:0];
      end
      blk_n = '0;
      blk_sum = 0;
      blk_sumsq = 0;
    end
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      expected_verdicts.delete();
      mismatches <= 0;
      ff_level = 16'd1536; imp_level = 16'd20480; look_depth = 8'd120; min_run = 8'd3;
      win_len = 16'd500; guard_len = 16'd50; margin = 16'd512; allowance = 16'd150;
      watching = 1'b0;
      foreach (history[i]) history[i] = fdb_pkg::ONE_G;
      slot = '0; fill = '0; since_impact = '0; motion_cnt = '0; blk_n = '0;
      blk_sum = 0; blk_sumsq = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fdb_pkg::CFG_FREEFALL:  ff_level = cfg_data;
          fdb_pkg::CFG_IMPACT:    imp_level = cfg_data;
          fdb_pkg::CFG_LOOKBACK:  look_depth = cfg_data[7:0];
          fdb_pkg::CFG_MIN_RUN:   min_run = cfg_data[7:0];
          fdb_pkg::CFG_WINDOW:    win_len = cfg_data;
          fdb_pkg::CFG_GUARD:     guard_len = cfg_data;
          fdb_pkg::CFG_MARGIN:    margin = cfg_data;
          fdb_pkg::CFG_ALLOWANCE: allowance = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_verdicts.push_back(predict_sample(accel_x, accel_y, accel_z, worn, block_end));
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          if (mismatches < 10) $display("unexpected result beat at %0t", $realtime);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_verdicts.pop_front();
          if (want.alert !== fall_alert || want.sd_valid !== motion_valid
              || want.sd !== motion_stddev) begin
            if (mismatches < 10)
              $display("mismatch at %0t: alert %b/%b valid %b/%b stddev %0d/%0d (exp/got)",
                       $realtime, want.alert, fall_alert, want.sd_valid, motion_valid,
                       want.sd, motion_stddev);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    outstanding <= expected_verdicts.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  typedef enum int {KIND_FREEFALL, KIND_REST, KIND_MOTION, KIND_IMPACT, KIND_NOISE} sample_kind_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic               worn = 1'b0, block_end = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               fall_alert, motion_valid;
  logic [19:0]        motion_stddev;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  int                 mismatches, outstanding;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int beats_sent = 0;

  // Settings per phase: freefall, impact, lookback, min run, window, guard, margin, allowance.
  logic [15:0] phase_cfg [8][8] = '{
    '{16'd1536,  16'd20480, 16'd120, 16'd3,   16'd20,    16'd4,     16'd512,   16'd10},
    '{16'd1536,  16'd20480, 16'd2,   16'd1,   16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd0,     16'd65535, 16'd128, 16'd128, 16'd65535, 16'd65535, 16'd65535, 16'd65535},
    '{16'd65535, 16'd0,     16'd128, 16'd0,   16'd5,     16'd0,     16'd65535, 16'd65535},
    '{16'd2000,  16'd15000, 16'd16,  16'd5,   16'd30,    16'd10,    16'd300,   16'd3},
    '{16'd1536,  16'd20480, 16'd1,   16'd0,   16'd8,     16'd2,     16'd512,   16'd150},
    '{16'd1536,  16'd20480, 16'd40,  16'd12,  16'd40,    16'd5,     16'd512,   16'd150},
    '{16'd1536,  16'd20480, 16'd60,  16'd3,   16'd25,    16'd0,     16'd0,     16'd65535}
  };

  fall_detector_backtrack_top i_dut (.*);

  fall_detector_checker i_checker (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  // Hard stop well beyond the slowest legal run.
  initial begin
    #200ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic signed [15:0] near(int centre, int spread);
    return 16'(centre + int'($urandom_range(2 * spread)) - spread);
  endfunction

  // Move one beat; hold valid high between back-to-back beats.
  task automatic send_beat(logic signed [15:0] ax, logic signed [15:0] ay,
                           logic signed [15:0] az, logic wn, logic last);
    // idling regime follows progress: receiver-heavy, then sender-heavy, then none
    if (beats_sent < 380) begin
      send_idle_pct = 33; recv_stall_pct = 86;
    end else if (beats_sent < 760) begin
      send_idle_pct = 86; recv_stall_pct = 33;
    end else begin
      send_idle_pct = 0; recv_stall_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    accel_x <= ax; accel_y <= ay; accel_z <= az;
    worn <= wn; block_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_kind(sample_kind_t kind);
    logic signed [15:0] ax, ay, az;
    int s;
    s = $urandom_range(1) ? 1 : -1;
    case (kind)
      KIND_FREEFALL: begin
        ax = near(0, 300); ay = near(0, 300); az = near(0, 300);
      end
      KIND_REST: begin
        ax = near(0, 120); ay = near(0, 120); az = near(s * 2048, 150);
      end
      KIND_MOTION: begin
        ax = near(0, 8000); ay = near(0, 8000); az = near(0, 8000);
      end
      KIND_IMPACT: begin
        ax = 16'(s * int'($urandom_range(12000, 32767)));
        ay = 16'(-s * int'($urandom_range(12000, 32767)));
        az = 16'(int'($urandom_range(24000)) - 12000);
      end
      default: begin
        ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
      end
    endcase
    send_beat(ax, ay, az, $urandom_range(99) < 85, $urandom_range(99) < 10);
  endtask

  // Drain the pipeline before touching the registers.
  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  // Hold the write for one edge; the caller drops the enable after the last one.
  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
  endtask

  initial begin
    int phase_beats;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: field extremes, single-sample block, a fall before the ring has filled.
    send_beat(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1);
    send_beat(16'sd32767, 16'sd32767, 16'sd32767, 1'b1, 1'b0);
    send_beat(-16'sd32768, -16'sd32768, -16'sd32768, 1'b1, 1'b0);
    send_beat(-16'sd32768, 16'sd0, 16'sd32767, 1'b0, 1'b1);
    send_beat(16'sd0, 16'sd0, 16'sd2048, 1'b1, 1'b1);
    repeat (4) send_kind(KIND_FREEFALL);
    send_kind(KIND_IMPACT);
    repeat (3) send_kind(KIND_REST);
    send_beat(16'sd0, 16'sd0, -16'sd2048, 1'b1, 1'b1);

    foreach (phase_cfg[p]) begin
      settle();
      write_reg(fdb_pkg::CFG_FREEFALL,  phase_cfg[p][0]);
      write_reg(fdb_pkg::CFG_IMPACT,    phase_cfg[p][1]);
      write_reg(fdb_pkg::CFG_LOOKBACK,  phase_cfg[p][2]);
      write_reg(fdb_pkg::CFG_MIN_RUN,   phase_cfg[p][3]);
      write_reg(fdb_pkg::CFG_WINDOW,    phase_cfg[p][4]);
      write_reg(fdb_pkg::CFG_GUARD,     phase_cfg[p][5]);
      write_reg(fdb_pkg::CFG_MARGIN,    phase_cfg[p][6]);
      write_reg(fdb_pkg::CFG_ALLOWANCE, phase_cfg[p][7]);
      cfg_we <= 1'b0;
      phase_beats = 0;
      while (phase_beats < 130) begin
        if ($urandom_range(99) < 60) begin
          // well-formed event: free-fall run, impact, then a quiet or restless window
          int ff_len, win;
          ff_len = $urandom_range(15);
          win = $urandom_range(40);
          repeat (ff_len) send_kind(KIND_FREEFALL);
          send_kind(KIND_IMPACT);
          repeat (win) send_kind(($urandom_range(99) < 80) ? KIND_REST : KIND_MOTION);
          phase_beats += ff_len + win + 1;
        end else begin
          int len;
          len = $urandom_range(1, 6);
          repeat (len) send_kind(sample_kind_t'($urandom_range(4)));
          phase_beats += len;
        end
      end
    end

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== fall_detector_backtrack_top.f =====
+incdir+rtl
rtl/fdb_pkg.sv
rtl/fdb_isqrt.sv
rtl/fdb_ctrl.sv
rtl/fdb_datapath.sv
rtl/fall_detector_backtrack_top.sv
bench/fall_detector_checker.sv
bench/testbench.sv
